/* rtl/vt4_pkg.sv */
// Shared types and constants for the 4x4 vertex transform.
package vt4_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 64;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int MAT_IDX_W = $clog2(NUM_REGS);
    localparam int SUM_W     = 66;
    localparam int Q_BITS    = 32;

    localparam logic OP_POINT     = 1'b0;
    localparam logic OP_DIRECTION = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] in_x;
        logic signed [DATA_W-1:0] in_y;
        logic signed [DATA_W-1:0] in_z;
    } t_vt_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic                     divide_skipped;
        logic                     clipped;
    } t_vt_out;

endpackage

/* rtl/vertex_transform_4x4.sv */
// Top level of the pipelined 4x4 homogeneous vertex transform.
// One request enters per clock while the pipe advances, and its result is presented after
// the request has passed through Q_BITS + 4 register stages:
// one stage of twelve 32x32 multipliers, one stage that sums and rounds each
// column, one stage that takes magnitudes and checks w and divide overflow,
// Q_BITS restoring divide stages (one quotient bit each, three lanes for x, y, z)
// and a saturating output register. The whole pipe advances whenever the output
// register is empty or being taken, so a full pipe with a ready sink sustains one
// result per clock. The matrix sits in eight 64-bit registers written through
// i_cfg_we/i_cfg_idx/i_cfg_data; reset loads identity. Write it only while idle.
module vertex_transform_4x4 #(
    parameter int FRAC_BITS = 16,
    parameter int W_EPSILON = 66
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  vt4_pkg::t_vt_in           i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output vt4_pkg::t_vt_out          o_out_data,
    input  logic                      i_cfg_we,
    input  logic [vt4_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vt4_pkg::CFG_W-1:0] i_cfg_data
);
    import vt4_pkg::*;

    localparam int RES_W = SUM_W - FRAC_BITS;   // rounded dot product width
    localparam int DW    = SUM_W + Q_BITS;      // divider remainder width
    localparam int MAG_W = RES_W + 1;

    // matrix registers
    logic [CFG_W-1:0] r_mat [NUM_REGS];

    // advance the whole pipe when the output slot is empty or being taken
    logic en;

    // stage 1: products
    logic                     r1_v;
    logic                     r1_op;
    logic signed [2*DATA_W-1:0] r1_p [3][4];
    logic signed [DATA_W-1:0]   r1_h [4];

    // stage 2: rounded columns
    logic                    r2_v;
    logic                    r2_op;
    logic signed [RES_W-1:0] r2_res [4];
    logic signed [SUM_W-1:0] n2_sum [4];

    // divider pipe, index 0 is the setup stage
    logic             r_dv   [Q_BITS+1];
    logic             r_skip [Q_BITS+1];
    logic             r_byp  [Q_BITS+1];
    logic [RES_W-1:0] r_ud   [Q_BITS+1];
    logic [DW-1:0]    r_rem  [Q_BITS+1][3];
    logic [Q_BITS-1:0] r_q   [Q_BITS+1][3];
    logic             r_neg  [Q_BITS+1][3];
    logic             r_ovf  [Q_BITS+1][3];

    // setup stage signals
    logic [RES_W-1:0] n_wmag;
    logic             n_divide;
    logic [RES_W-1:0] n_mag [3];

    // output
    logic    r_ov;
    t_vt_out r_out;
    t_vt_out n_out;

    function automatic logic signed [DATA_W-1:0] mat_entry(input int r, input int c);
        return r_mat[r*2 + c/2][(c%2)*DATA_W +: DATA_W];
    endfunction

    function automatic logic [RES_W-1:0] mag_of(input logic signed [RES_W-1:0] v);
        return v[RES_W-1] ? RES_W'(-v) : RES_W'(v);
    endfunction

    assign en         = !r_ov || i_out_ready;
    assign o_in_ready = en;

    // configuration: unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= CFG_W'(64'h0000_0000_0001_0000);
            r_mat[1] <= '0;
            r_mat[2] <= CFG_W'(64'h0001_0000_0000_0000);
            r_mat[3] <= '0;
            r_mat[4] <= '0;
            r_mat[5] <= CFG_W'(64'h0000_0000_0001_0000);
            r_mat[6] <= '0;
            r_mat[7] <= CFG_W'(64'h0001_0000_0000_0000);
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_REGS))) begin
            r_mat[i_cfg_idx[MAT_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r_dv[0] <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v    <= i_in_valid;
            r2_v    <= r1_v;
            r_dv[0] <= r2_v;
            r_ov    <= r_dv[Q_BITS];
        end
    end

    // stage 1: row vector times matrix, the homogeneous row needs no multiply
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op <= i_in_data.opcode;
            for (int c = 0; c < 4; c++) begin
                r1_p[0][c] <= i_in_data.in_x * mat_entry(0, c);
                r1_p[1][c] <= i_in_data.in_y * mat_entry(1, c);
                r1_p[2][c] <= i_in_data.in_z * mat_entry(2, c);
                r1_h[c]    <= (i_in_data.opcode == OP_POINT) ? mat_entry(3, c) : '0;
            end
        end
    end

    // stage 2: exact sum, add half an LSB, floor
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n2_sum[c] = SUM_W'(r1_p[0][c]) + SUM_W'(r1_p[1][c]) + SUM_W'(r1_p[2][c])
                      + (SUM_W'(r1_h[c]) <<< FRAC_BITS)
                      + (SUM_W'(1) << (FRAC_BITS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op <= r1_op;
            for (int c = 0; c < 4; c++) begin
                r2_res[c] <= RES_W'(n2_sum[c] >>> FRAC_BITS);
            end
        end
    end

    // stage 3: decide divide or bypass; bypass runs through with an all-ones
    // divisor so no quotient bit ever sets and the remainder keeps the value
    always_comb begin
        n_wmag   = mag_of(r2_res[3]);
        n_divide = (r2_op == OP_POINT) && (n_wmag > RES_W'(W_EPSILON));
        for (int j = 0; j < 3; j++) begin
            n_mag[j] = mag_of(r2_res[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_skip[0] <= (r2_op == OP_POINT) && !n_divide;
            r_byp[0]  <= !n_divide;
            r_ud[0]   <= n_divide ? n_wmag : '1;
            for (int j = 0; j < 3; j++) begin
                r_q[0][j] <= '0;
                if (n_divide) begin
                    r_rem[0][j] <= DW'({n_mag[j], {FRAC_BITS{1'b0}}});
                    r_neg[0][j] <= r2_res[j][RES_W-1] ^ r2_res[3][RES_W-1];
                    r_ovf[0][j] <= DW'({n_mag[j], {FRAC_BITS{1'b0}}})
                                   >= (DW'(n_wmag) << Q_BITS);
                end else begin
                    r_rem[0][j] <= DW'(n_mag[j]);
                    r_neg[0][j] <= r2_res[j][RES_W-1];
                    r_ovf[0][j] <= 1'b0;
                end
            end
        end
    end

    // restoring divide, one quotient bit per stage, MSB first
    for (genvar s = 0; s < Q_BITS; s++) begin : g_div
        localparam int B = Q_BITS - 1 - s;
        logic [DW-1:0] d_sh;
        assign d_sh = DW'(r_ud[s]) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s+1] <= 1'b0;
            end else if (en) begin
                r_dv[s+1] <= r_dv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_skip[s+1] <= r_skip[s];
                r_byp[s+1]  <= r_byp[s];
                r_ud[s+1]   <= r_ud[s];
                for (int j = 0; j < 3; j++) begin
                    r_neg[s+1][j] <= r_neg[s][j];
                    r_ovf[s+1][j] <= r_ovf[s][j];
                    if (r_rem[s][j] >= d_sh) begin
                        r_rem[s+1][j] <= r_rem[s][j] - d_sh;
                        r_q[s+1][j]   <= r_q[s][j] | (Q_BITS'(1) << B);
                    end else begin
                        r_rem[s+1][j] <= r_rem[s][j];
                        r_q[s+1][j]   <= r_q[s][j];
                    end
                end
            end
        end
    end : g_div

    // output: apply sign, saturate, flag
    always_comb begin
        logic [MAG_W-1:0]        mag;
        logic signed [MAG_W:0]   sv;
        logic                    clip;
        logic signed [DATA_W-1:0] ov [3];
        clip = 1'b0;
        for (int j = 0; j < 3; j++) begin
            if (r_byp[Q_BITS]) begin
                mag = MAG_W'(r_rem[Q_BITS][j][RES_W-1:0]);
            end else if (r_ovf[Q_BITS][j]) begin
                mag = MAG_W'(1) << Q_BITS;
            end else begin
                mag = MAG_W'(r_q[Q_BITS][j]);
            end
            sv = r_neg[Q_BITS][j] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            if (sv > (MAG_W+1)'(2147483647)) begin
                ov[j] = 32'sh7fff_ffff;
                clip  = 1'b1;
            end else if (sv < -$signed((MAG_W+1)'(64'sd2147483648))) begin
                ov[j] = 32'sh8000_0000;
                clip  = 1'b1;
            end else begin
                ov[j] = DATA_W'(sv);
            end
        end
        n_out.out_x          = ov[0];
        n_out.out_y          = ov[1];
        n_out.out_z          = ov[2];
        n_out.divide_skipped = r_skip[Q_BITS];
        n_out.clipped        = clip;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

/* rtl/vt4_checker.sv */
// Port-level checker for the vertex transform, bound to the top level.
module vt4_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input vt4_pkg::t_vt_out o_out_data
);
    import vt4_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("request refused with output free");

    a_clip_means_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.clipped |->
            o_out_data.out_x == 32'sh7fff_ffff || o_out_data.out_x == 32'sh8000_0000 ||
            o_out_data.out_y == 32'sh7fff_ffff || o_out_data.out_y == 32'sh8000_0000 ||
            o_out_data.out_z == 32'sh7fff_ffff || o_out_data.out_z == 32'sh8000_0000)
        else $error("clip flag without a saturated component");

endmodule

bind vertex_transform_4x4 vt4_checker u_vt4_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
